// ----- rtl/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared widths, state encoding and controller command group.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int SEED_WIDTH      = 32;
   localparam int BITS_LEFT_WIDTH = 6;
   localparam int REQ_TDATA_WIDTH = 16;
   // median (16) + seed_ready (1) + seed_word (32) = 49, padded to 56
   localparam int RSP_TDATA_WIDTH = 56;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PUBLISH
   } swm_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // take a new sample into the window and seed
      logic rotate;   // rank the head entry and rotate the window by one
      logic publish;  // copy the result into the output register
   } swm_cmd_type;

endpackage

// ----- rtl/swm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sliding window median controller
// Sequences accept, window scan and result publish; owns the handshakes.
// ----------------------------------------------------------------------------
module swm_ctrl #(
   parameter int WINDOW_SIZE = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output swm_pkg::swm_cmd_type cmd
);

   localparam int CNT_WIDTH = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam logic [CNT_WIDTH-1:0] LAST_POS = CNT_WIDTH'(WINDOW_SIZE - 1);

   swm_pkg::swm_state_type state_ff, state_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // State, scan counter and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         swm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = swm_pkg::ST_SCAN;
            end
         end
         swm_pkg::ST_SCAN: begin
            cmd.rotate = 1'b1;
            if (cnt_ff == LAST_POS) begin
               cnt_in   = '0;
               state_in = swm_pkg::ST_PUBLISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         swm_pkg::ST_PUBLISH: begin
            // hold until the output register is free or being emptied
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = swm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swm_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/swm_dpath.sv -----
// ----------------------------------------------------------------------------
// Sliding window median datapath
// Window shift line, rank comparators, seed collector and output register.
// ----------------------------------------------------------------------------
module swm_dpath #(
   parameter int WINDOW_SIZE = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swm_pkg::swm_cmd_type                 cmd,
   input  logic [swm_pkg::SAMPLE_WIDTH-1:0]     sample,
   output logic [swm_pkg::SAMPLE_WIDTH-1:0]     median,
   output logic                                 seed_ready,
   output logic [swm_pkg::SEED_WIDTH-1:0]       seed_word
);

   localparam int RANK_WIDTH = $clog2(WINDOW_SIZE + 1);
   localparam logic [RANK_WIDTH-1:0] MID_RANK = RANK_WIDTH'(WINDOW_SIZE / 2);

   logic [swm_pkg::SAMPLE_WIDTH-1:0]    window_ff [WINDOW_SIZE];
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    window_in [WINDOW_SIZE];
   logic                                awaiting_first_ff, awaiting_first_in;
   logic [swm_pkg::SEED_WIDTH-1:0]      seed_bits_ff, seed_bits_in;
   logic [swm_pkg::BITS_LEFT_WIDTH-1:0] bits_left_ff, bits_left_in;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    found_ff, found_in;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    median_ff, median_in;
   logic                                ready_ff, ready_in;
   logic [swm_pkg::SEED_WIDTH-1:0]      word_ff, word_in;

   logic [WINDOW_SIZE-1:0]              lt_vec, le_vec;
   logic [RANK_WIDTH-1:0]               lt_cnt, le_cnt;
   logic                                head_match;

   // Compare the head entry against every entry of the window
   always_comb begin
      for (int j = 0; j < WINDOW_SIZE; j++) begin
         lt_vec[j] = window_ff[j] <  window_ff[0];
         le_vec[j] = window_ff[j] <= window_ff[0];
      end
      lt_cnt     = RANK_WIDTH'($countones(lt_vec));
      le_cnt     = RANK_WIDTH'($countones(le_vec));
      // head value covers the middle rank
      head_match = (lt_cnt <= MID_RANK) && (le_cnt > MID_RANK);
   end

   // Window update: fill, shift in, or rotate during the scan
   always_comb begin
      for (int j = 0; j < WINDOW_SIZE; j++) begin
         window_in[j] = window_ff[j];
      end
      awaiting_first_in = awaiting_first_ff;
      if (cmd.load) begin
         awaiting_first_in = 1'b0;
         if (awaiting_first_ff) begin
            for (int j = 0; j < WINDOW_SIZE; j++) begin
               window_in[j] = sample;
            end
         end else begin
            window_in[0] = sample;
            for (int j = 1; j < WINDOW_SIZE; j++) begin
               window_in[j] = window_ff[j-1];
            end
         end
      end else if (cmd.rotate) begin
         window_in[WINDOW_SIZE-1] = window_ff[0];
         for (int j = 0; j < WINDOW_SIZE - 1; j++) begin
            window_in[j] = window_ff[j+1];
         end
      end
   end

   // Seed collector and result capture
   always_comb begin
      seed_bits_in = seed_bits_ff;
      bits_left_in = bits_left_ff;
      found_in     = found_ff;
      median_in    = median_ff;
      ready_in     = ready_ff;
      word_in      = word_ff;
      if (cmd.load && (bits_left_ff != '0)) begin
         seed_bits_in = {seed_bits_ff[swm_pkg::SEED_WIDTH-2:0], sample[0]};
         bits_left_in = bits_left_ff - 1'b1;
      end
      if (cmd.rotate && head_match) begin
         found_in = window_ff[0];
      end
      if (cmd.publish) begin
         median_in = found_ff;
         ready_in  = (bits_left_ff == '0);
         word_in   = seed_bits_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_first_ff <= 1'b1;
         seed_bits_ff      <= '0;
         bits_left_ff      <= swm_pkg::BITS_LEFT_WIDTH'(swm_pkg::SEED_WIDTH);
      end else begin
         awaiting_first_ff <= awaiting_first_in;
         seed_bits_ff      <= seed_bits_in;
         bits_left_ff      <= bits_left_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int j = 0; j < WINDOW_SIZE; j++) begin
         window_ff[j] <= window_in[j];
      end
      found_ff  <= found_in;
      median_ff <= median_in;
      ready_ff  <= ready_in;
      word_ff   <= word_in;
   end

   assign median     = median_ff;
   assign seed_ready = ready_ff;
   assign seed_word  = word_ff;

endmodule

// ----- rtl/sliding_window_median_with_seed.sv -----
// ----------------------------------------------------------------------------
// Sliding window median filter with seed collector
// Median of the last WINDOW_SIZE samples plus a 32-bit seed from sample LSBs.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one 16-bit unsigned sample per item. rsp_* returns one item
//   per sample: the window element of rank WINDOW_SIZE/2, the seed ready flag
//   and the seed word. The first sample after reset fills the whole window.
//   The result reaches the output register through the accept state, the
//   scan state, in which the window rotates through every entry past two
//   banks of WINDOW_SIZE comparators and two ones counters, and the publish
//   state. A new item is accepted only once the previous one has been
//   published.
//   The output register holds a finished result while the receiver stalls;
//   the next item is still accepted and scanned, and waits in the publish
//   step until the register frees up, so each stall delays it further.
//   Synchronous reset arms the window to be filled by the next sample, clears
//   the seed and drops any pending result.
// ----------------------------------------------------------------------------
module sliding_window_median_with_seed #(
   parameter int WINDOW_SIZE = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] sample
   input  logic [swm_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] median, [16] seed_ready, [48:17] seed_word, [55:49] zero
   output logic [swm_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata
);

   swm_pkg::swm_cmd_type              cmd;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]  median;
   logic                              seed_ready;
   logic [swm_pkg::SEED_WIDTH-1:0]    seed_word;

   swm_ctrl #(
      .WINDOW_SIZE(WINDOW_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   swm_dpath #(
      .WINDOW_SIZE(WINDOW_SIZE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample     (req_tdata[swm_pkg::SAMPLE_WIDTH-1:0]),
      .median     (median),
      .seed_ready (seed_ready),
      .seed_word  (seed_word)
   );

   // Pack the result fields, lowest first
   assign rsp_tdata = {7'd0, seed_word, seed_ready, median};

endmodule

// ----- sim/median_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter result checker
// Watches both item channels of the median filter, keeps its own window,
// write slot and seed shift register, and compares every result item field
// by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module median_checker #(
   parameter int WINDOW_SIZE = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // [15:0] sample
   input  logic [swm_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] median, [16] seed_ready, [48:17] seed_word, [55:49] zero
   input  logic [swm_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   output int                                   mismatch_count,
   output int                                   result_backlog
);

   typedef struct packed {
      logic [swm_pkg::SAMPLE_WIDTH-1:0] median;
      logic                             seed_ready;
      logic [swm_pkg::SEED_WIDTH-1:0]   seed_word;
   } filter_result_type;

   // Predicted filter state
   logic [swm_pkg::SAMPLE_WIDTH-1:0]    window_q [WINDOW_SIZE];
   int unsigned                         slot;
   bit                                  fill_pending;
   logic [swm_pkg::SEED_WIDTH-1:0]      seed_acc;
   logic [swm_pkg::BITS_LEFT_WIDTH-1:0] seed_bits_left;

   filter_result_type                   expected_results [$];
   int                                  error_tally;

   // Sort a copy of the window and take the element of rank WINDOW_SIZE/2
   function automatic logic [swm_pkg::SAMPLE_WIDTH-1:0] middle_rank();
      logic [swm_pkg::SAMPLE_WIDTH-1:0] sorted [WINDOW_SIZE];
      logic [swm_pkg::SAMPLE_WIDTH-1:0] v;
      int                               b;
      for (int a = 0; a < WINDOW_SIZE; a++) sorted[a] = window_q[a];
      for (int a = 1; a < WINDOW_SIZE; a++) begin
         v = sorted[a];
         b = a;
         while (b > 0 && sorted[b-1] > v) begin
            sorted[b] = sorted[b-1];
            b--;
         end
         sorted[b] = v;
      end
      return sorted[WINDOW_SIZE/2];
   endfunction

   // Take one sample into the seed and the window, then rank the window
   function automatic filter_result_type absorb_sample(
      input logic [swm_pkg::SAMPLE_WIDTH-1:0] s
   );
      filter_result_type r;
      if (seed_bits_left != 0) begin
         seed_acc       = {seed_acc[swm_pkg::SEED_WIDTH-2:0], s[0]};
         seed_bits_left = seed_bits_left - 1'b1;
      end
      if (fill_pending) begin
         // first sample after reset fills every entry, slot stays put
         fill_pending = 1'b0;
         for (int a = 0; a < WINDOW_SIZE; a++) window_q[a] = s;
      end else begin
         window_q[slot] = s;
         slot = (slot + 1 >= WINDOW_SIZE) ? 0 : slot + 1;
      end
      r.median     = middle_rank();
      r.seed_ready = (seed_bits_left == 0);
      r.seed_word  = seed_acc;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      filter_result_type got;
      filter_result_type want;
      logic [6:0]        pad;
      if (reset) begin
         for (int a = 0; a < WINDOW_SIZE; a++) window_q[a] = '0;
         slot           = 0;
         fill_pending   = 1'b1;
         seed_acc       = '0;
         seed_bits_left = swm_pkg::BITS_LEFT_WIDTH'(swm_pkg::SEED_WIDTH);
         expected_results.delete();
      end else begin
         // predict each accepted sample
         if (req_tvalid && req_tready)
            expected_results.push_back(absorb_sample(req_tdata[swm_pkg::SAMPLE_WIDTH-1:0]));

         // compare each accepted result with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.median     = rsp_tdata[15:0];
            got.seed_ready = rsp_tdata[16];
            got.seed_word  = rsp_tdata[48:17];
            pad            = rsp_tdata[55:49];
            if (expected_results.size() == 0) begin
               if (error_tally < 10)
                  $display("[%0t] result item with none expected: median=%h ready=%b seed=%h",
                           $time, got.median, got.seed_ready, got.seed_word);
               error_tally++;
            end else begin
               want = expected_results.pop_front();
               if (got != want || pad != '0) begin
                  if (error_tally < 10) begin
                     $display("[%0t] mismatch: expected median=%h ready=%b seed=%h pad=00",
                              $time, want.median, want.seed_ready, want.seed_word);
                     $display("[%0t]                got median=%h ready=%b seed=%h pad=%h",
                              $time, got.median, got.seed_ready, got.seed_word, pad);
                  end
                  error_tally++;
               end
            end
         end
      end
      mismatch_count <= error_tally;
      result_backlog <= expected_results.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter testbench
// Drives directed and random samples into the sliding window median filter
// with random gaps and output stalls; a separate checker predicts and
// compares every result item and reports its mismatch count here.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WINDOW_SIZE    = 8;
   localparam int RANDOM_ITEMS   = 380;
   localparam int STEADY_ITEMS   = 60;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 4 * (WINDOW_SIZE + 2);

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic [swm_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata  = '0;
   logic                                 rsp_tready = 1'b0;
   logic                                 req_tready;
   logic                                 rsp_tvalid;
   logic [swm_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata;

   int                                   mismatch_count;
   int                                   result_backlog;
   bit                                   idle_enable = 1'b0;
   int                                   stall_left  = 0;
   int                                   quiet_cycles = 0;
   logic [swm_pkg::SAMPLE_WIDTH-1:0]     last_sample = '0;

   sliding_window_median_with_seed #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   median_checker #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .result_backlog (result_backlog)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Stall the result channel at random while idling is on
   always @(posedge clock) begin
      if (reset || !idle_enable) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // End the run when no item moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mix of extremes, near-duplicates, repeats and full-range values
   function automatic logic [swm_pkg::SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 3));
         3:       return 16'hFFFF - 16'($urandom_range(0, 3));
         4:       return last_sample;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one sample and hold it until accepted, then maybe idle
   task automatic send_sample(input logic [swm_pkg::SAMPLE_WIDTH-1:0] s);
      req_tdata   <= s;
      req_tvalid  <= 1'b1;
      last_sample = s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      logic [swm_pkg::SAMPLE_WIDTH-1:0] directed [20];

      directed = '{
         16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001,
         16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'hFFFE,
         16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 16'h0000,
         16'h0000, 16'hFFFF, 16'h0001, 16'h1234, 16'hFFFF
      };

      repeat (9) @(posedge clock);
      reset       <= 1'b0;
      idle_enable <= 1'b1;
      @(posedge clock);

      // first sample fills the window; then extremes and duplicate runs
      foreach (directed[i]) send_sample(directed[i]);

      // hold off until every outstanding result has drained
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (result_backlog != 0) @(posedge clock);

      // random part: alternate idle and calm stretches, calm at the end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_enable <= (i < RANDOM_ITEMS - STEADY_ITEMS) && ((i / 64) % 3 != 2);
         send_sample(pick_sample());
      end

      // drain, then allow stray results to show up
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (result_backlog != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && result_backlog == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
